// ----- src/slwc_pkg.sv -----
// Package for the size-weighted LRU cache directory.
// Holds widths, register indexes, directory op codes and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slwc_pkg;

	// Table and field widths
	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int SIZE_W  = 16;
	localparam int CAP_W   = 20;

	// Configuration port
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam logic [0:0] REG_MAX_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(65536);

	// Directory operations
	localparam logic [1:0] DIR_NOP    = 2'd0;
	localparam logic [1:0] DIR_TOUCH  = 2'd1;
	localparam logic [1:0] DIR_EVICT  = 2'd2;
	localparam logic [1:0] DIR_INSERT = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [IDX_W-1:0]  idx;
		logic [IDX_W-1:0]  rank;
		logic [IDX_W-1:0]  ref_rank;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
	} dir_cmd_t;

	typedef struct packed {
		logic              rd_valid;
		logic [KEY_W-1:0]  rd_key;
		logic [IDX_W-1:0]  rd_rank;
		logic [IDX_W-1:0]  victim;
		logic [SIZE_W-1:0] victim_size;
		logic [IDX_W-1:0]  free_slot;
	} dir_stat_t;

endpackage

`default_nettype wire

// ----- src/slwc_dir.sv -----
// Entry table: keys, sizes, valid bits and recency ranks.
// Applies touch, evict and insert commands; reports the scanned entry, LRU victim, free slot.
// Depends on slwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slwc_dir (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire [slwc_pkg::IDX_W-1:0]   scan_idx,
	input  wire slwc_pkg::dir_cmd_t     cmd,
	output slwc_pkg::dir_stat_t         stat
);

	logic [slwc_pkg::KEY_W-1:0]  keys_q  [slwc_pkg::ENTRIES];
	logic [slwc_pkg::SIZE_W-1:0] sizes_q [slwc_pkg::ENTRIES];
	logic [slwc_pkg::ENTRIES-1:0] valid_q;
	logic [slwc_pkg::IDX_W-1:0]  rank_q  [slwc_pkg::ENTRIES];

	logic [slwc_pkg::IDX_W-1:0] victim;
	logic [slwc_pkg::IDX_W-1:0] free_slot;

	// LRU victim and lowest free slot, lowest index wins
	always_comb begin
		victim    = '0;
		free_slot = '0;
		for (int i = slwc_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && rank_q[i] == '0) begin
				victim = slwc_pkg::IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_slot = slwc_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		stat.rd_valid    = valid_q[scan_idx];
		stat.rd_key      = keys_q[scan_idx];
		stat.rd_rank     = rank_q[scan_idx];
		stat.victim      = victim;
		stat.victim_size = sizes_q[victim];
		stat.free_slot   = free_slot;
	end

	// Payload storage, written on insert only
	always_ff @(posedge clk) begin
		if (cmd.op == slwc_pkg::DIR_INSERT) begin
			keys_q[cmd.idx]  <= cmd.key;
			sizes_q[cmd.idx] <= cmd.size;
		end
	end

	// Valid bits and recency ranks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < slwc_pkg::ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			case (cmd.op)
				slwc_pkg::DIR_TOUCH: begin
					for (int i = 0; i < slwc_pkg::ENTRIES; i++) begin
						if (valid_q[i] && rank_q[i] > cmd.ref_rank) begin
							rank_q[i] <= rank_q[i] - 1'b1;
						end
					end
					rank_q[cmd.idx] <= cmd.rank;
				end
				slwc_pkg::DIR_EVICT: begin
					for (int i = 0; i < slwc_pkg::ENTRIES; i++) begin
						if (valid_q[i] && rank_q[i] != '0) begin
							rank_q[i] <= rank_q[i] - 1'b1;
						end
					end
					valid_q[cmd.idx] <= 1'b0;
					rank_q[cmd.idx]  <= '0;
				end
				slwc_pkg::DIR_INSERT: begin
					valid_q[cmd.idx] <= 1'b1;
					rank_q[cmd.idx]  <= cmd.rank;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/slwc_seq.sv -----
// Request sequencer: key scan, hit/miss decision, eviction loop, insert, result register.
// One shared add/subtract unit serves the budget check and the occupancy updates.
// Depends on slwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slwc_seq (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [slwc_pkg::CAP_W-1:0]   max_capacity,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [slwc_pkg::KEY_W-1:0]   item_key,
	input  wire  [slwc_pkg::SIZE_W-1:0]  item_size,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         hit,
	output logic                         stored,
	output logic [4:0]                   evicted_count,
	output logic [slwc_pkg::CAP_W-1:0]   used_total,
	output logic [slwc_pkg::IDX_W-1:0]   scan_idx,
	output slwc_pkg::dir_cmd_t           cmd,
	input  wire slwc_pkg::dir_stat_t     stat
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_CHECK  = 3'd3;
	localparam logic [2:0] S_EVICT  = 3'd4;
	localparam logic [2:0] S_INSERT = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]                   state_q;
	logic [slwc_pkg::KEY_W-1:0]   key_q;
	logic [slwc_pkg::SIZE_W-1:0]  size_q;
	logic [slwc_pkg::IDX_W-1:0]   idx_q;
	logic                         found_q;
	logic [slwc_pkg::IDX_W-1:0]   found_idx_q;
	logic [slwc_pkg::IDX_W-1:0]   found_rank_q;
	logic [slwc_pkg::CNT_W-1:0]   count_q;
	logic [slwc_pkg::CAP_W-1:0]   occ_q;
	logic [4:0]                   evict_q;
	logic                         hit_q;
	logic                         stored_q;

	logic [slwc_pkg::SIZE_W-1:0]  operand;
	logic [slwc_pkg::CAP_W:0]     alu_out;
	logic                         must_evict;
	logic                         scan_match;

	// Shared adder: subtract victim size on evict, add request size otherwise
	always_comb begin
		operand = (state_q == S_EVICT) ? stat.victim_size : size_q;
		if (state_q == S_EVICT) begin
			alu_out = {1'b0, occ_q} - (slwc_pkg::CAP_W + 1)'(operand);
		end else begin
			alu_out = {1'b0, occ_q} + (slwc_pkg::CAP_W + 1)'(operand);
		end
	end

	assign must_evict = (count_q != '0) &&
		((alu_out > {1'b0, max_capacity}) ||
		 (count_q >= slwc_pkg::CNT_W'(slwc_pkg::ENTRIES)));

	assign scan_match = stat.rd_valid && (stat.rd_key == key_q);

	// Directory command for the current step
	always_comb begin
		cmd          = '0;
		cmd.op       = slwc_pkg::DIR_NOP;
		cmd.key      = key_q;
		cmd.size     = size_q;
		cmd.ref_rank = found_rank_q;
		case (state_q)
			S_DECIDE: begin
				if (found_q) begin
					cmd.op   = slwc_pkg::DIR_TOUCH;
					cmd.idx  = found_idx_q;
					cmd.rank = slwc_pkg::IDX_W'(count_q - 1'b1);
				end
			end
			S_EVICT: begin
				cmd.op  = slwc_pkg::DIR_EVICT;
				cmd.idx = stat.victim;
			end
			S_INSERT: begin
				cmd.op   = slwc_pkg::DIR_INSERT;
				cmd.idx  = stat.free_slot;
				cmd.rank = slwc_pkg::IDX_W'(count_q);
			end
			default: begin
			end
		endcase
	end

	assign scan_idx      = idx_q;
	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = (state_q == S_DONE);
	assign hit           = hit_q;
	assign stored        = stored_q;
	assign evicted_count = evict_q;
	assign used_total    = occ_q;

	// Request payload
	always_ff @(posedge clk) begin
		if (in_valid && state_q == S_IDLE) begin
			key_q  <= item_key;
			size_q <= item_size;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			found_q      <= 1'b0;
			found_idx_q  <= '0;
			found_rank_q <= '0;
			count_q      <= '0;
			occ_q        <= '0;
			evict_q      <= '0;
			hit_q        <= 1'b0;
			stored_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q    <= '0;
						found_q  <= 1'b0;
						evict_q  <= '0;
						hit_q    <= 1'b0;
						stored_q <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				// one entry compared per cycle
				S_SCAN: begin
					if (scan_match) begin
						found_q      <= 1'b1;
						found_idx_q  <= idx_q;
						found_rank_q <= stat.rd_rank;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == slwc_pkg::IDX_W'(slwc_pkg::ENTRIES - 1)) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (found_q) begin
						hit_q    <= 1'b1;
						stored_q <= 1'b1;
						state_q  <= S_DONE;
					end else if (slwc_pkg::CAP_W'(size_q) > max_capacity) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= must_evict ? S_EVICT : S_INSERT;
				end
				S_EVICT: begin
					occ_q   <= alu_out[slwc_pkg::CAP_W-1:0];
					count_q <= count_q - 1'b1;
					evict_q <= evict_q + 1'b1;
					state_q <= S_CHECK;
				end
				S_INSERT: begin
					occ_q    <= alu_out[slwc_pkg::CAP_W-1:0];
					count_q  <= count_q + 1'b1;
					stored_q <= 1'b1;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/size_weighted_lru_cache.sv -----
// Size-weighted LRU cache directory, top level.
// Budget register on the APB-style port; instantiates slwc_seq and slwc_dir.
// Depends on slwc_pkg, slwc_dir, slwc_seq.
//
// Usage:
//   Requests (item_key, item_size) enter on in_valid/in_ready; one result
//   (hit, stored, evicted_count, used_total) leaves on out_valid/out_ready.
//   One item is processed at a time; in_ready is high only while idle.
//   From accept to out_valid, the item passes the key scan through the entry
//   table (one entry per cycle), then the hit/miss decision. A hit or an item
//   too large for the budget then completes; a stored miss runs the eviction
//   loop (check, then remove, on one shared adder) per evicted entry, then inserts.
//   The result stays held while out_ready is low; no new item is taken then.
//   Reset clears the table (all entries invalid), the occupancy total and sets
//   max_capacity to 65536. max_capacity is written at byte address 0 and may be
//   changed only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module size_weighted_lru_cache (
	input  wire                           clk,
	input  wire                           arst_n,
	// configuration port
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [slwc_pkg::ADDR_W-1:0]   paddr,
	input  wire  [slwc_pkg::DATA_W-1:0]   pwdata,
	output logic [slwc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// request channel
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [slwc_pkg::KEY_W-1:0]    item_key,
	input  wire  [slwc_pkg::SIZE_W-1:0]   item_size,
	// result channel
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          hit,
	output logic                          stored,
	output logic [4:0]                    evicted_count,
	output logic [slwc_pkg::CAP_W-1:0]    used_total
);

	logic [slwc_pkg::CAP_W-1:0]  max_capacity_q;
	logic                        reg_sel;
	logic [slwc_pkg::IDX_W-1:0]  scan_idx;
	slwc_pkg::dir_cmd_t          dir_cmd;
	slwc_pkg::dir_stat_t         dir_stat;

	// Budget register
	assign reg_sel = (paddr[2] == slwc_pkg::REG_MAX_CAPACITY);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_capacity_q <= slwc_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			max_capacity_q <= pwdata[slwc_pkg::CAP_W-1:0];
		end
	end

	assign prdata = reg_sel ? slwc_pkg::DATA_W'(max_capacity_q) : '0;

	slwc_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_capacity  (max_capacity_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.item_key      (item_key),
		.item_size     (item_size),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.stored        (stored),
		.evicted_count (evicted_count),
		.used_total    (used_total),
		.scan_idx      (scan_idx),
		.cmd           (dir_cmd),
		.stat          (dir_stat)
	);

	slwc_dir u_dir (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan_idx (scan_idx),
		.cmd      (dir_cmd),
		.stat     (dir_stat)
	);

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for the size-weighted LRU cache directory (size_weighted_lru_cache).
// Runs a directed table, then random phases, and checks each result against a local model.
// Depends on slwc_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb_top;

	// Register index with no register behind it; writes there must be dropped
	localparam int REG_UNUSED = 1;
	localparam int KEY_POOL   = 20;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 119;

	typedef struct packed {
		logic                       hit;
		logic                       stored;
		logic [4:0]                 evicted;
		logic [slwc_pkg::CAP_W-1:0] used;
	} lookup_res_t;

	typedef enum logic {ROW_ITEM, ROW_BUDGET} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [31:0]                 budget_word;
		logic [slwc_pkg::KEY_W-1:0]  key;
		logic [slwc_pkg::SIZE_W-1:0] size;
		logic                        typed;
		lookup_res_t                 want;
	} plan_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [slwc_pkg::ADDR_W-1:0]   paddr;
	logic [slwc_pkg::DATA_W-1:0]   pwdata;
	logic [slwc_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_ready;
	logic [slwc_pkg::KEY_W-1:0]    item_key;
	logic [slwc_pkg::SIZE_W-1:0]   item_size;
	logic                          out_valid;
	logic                          out_ready;
	logic                          hit;
	logic                          stored;
	logic [4:0]                    evicted_count;
	logic [slwc_pkg::CAP_W-1:0]    used_total;

	size_weighted_lru_cache dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.item_key(item_key), .item_size(item_size),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .stored(stored), .evicted_count(evicted_count),
		.used_total(used_total)
	);

	// Local copy of the directory state
	logic [slwc_pkg::KEY_W-1:0]  cache_key  [slwc_pkg::ENTRIES];
	logic [slwc_pkg::SIZE_W-1:0] cache_size [slwc_pkg::ENTRIES];
	bit                          cache_live [slwc_pkg::ENTRIES];
	int                          cache_rank [slwc_pkg::ENTRIES];
	int                          occupied;
	int                          budget;

	lookup_res_t pending_results [$];
	int          mismatch_count;
	bit          calm;
	int          stall_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit: far above the slowest legal run
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int live_count();
		int n;
		n = 0;
		for (int i = 0; i < slwc_pkg::ENTRIES; i++)
			if (cache_live[i])
				n++;
		return n;
	endfunction

	// Expected result of one request; updates the local directory
	task automatic predict_lookup(input logic [slwc_pkg::KEY_W-1:0] k,
			input logic [slwc_pkg::SIZE_W-1:0] sz, output lookup_res_t r);
		int found;
		int slot;
		int victim;
		int rk;
		int n;
		found = -1;
		slot = -1;
		r = '0;
		for (int i = 0; i < slwc_pkg::ENTRIES; i++)
			if (cache_live[i] && cache_key[i] == k)
				found = i;
		if (found >= 0) begin
			// hit: move to most recent
			rk = cache_rank[found];
			n = live_count();
			for (int i = 0; i < slwc_pkg::ENTRIES; i++)
				if (cache_live[i] && cache_rank[i] > rk)
					cache_rank[i]--;
			cache_rank[found] = n - 1;
			r.hit = 1'b1;
			r.stored = 1'b1;
		end else if (int'(sz) <= budget) begin
			// evict oldest until the item fits and a slot is free
			while (occupied + int'(sz) > budget || live_count() >= slwc_pkg::ENTRIES) begin
				victim = -1;
				for (int i = 0; i < slwc_pkg::ENTRIES; i++)
					if (cache_live[i] && cache_rank[i] == 0)
						victim = i;
				if (victim < 0)
					break;
				cache_live[victim] = 1'b0;
				occupied -= int'(cache_size[victim]);
				cache_rank[victim] = 0;
				for (int i = 0; i < slwc_pkg::ENTRIES; i++)
					if (cache_live[i] && cache_rank[i] > 0)
						cache_rank[i]--;
				r.evicted++;
			end
			for (int i = slwc_pkg::ENTRIES - 1; i >= 0; i--)
				if (!cache_live[i])
					slot = i;
			if (slot >= 0) begin
				cache_rank[slot] = live_count();
				cache_key[slot] = k;
				cache_size[slot] = sz;
				cache_live[slot] = 1'b1;
				occupied += int'(sz);
				r.stored = 1'b1;
			end
		end
		r.used = slwc_pkg::CAP_W'(occupied);
	endtask

	// Present one item and hold it until taken; log the expected result
	task automatic send_item(input logic [slwc_pkg::KEY_W-1:0] k,
			input logic [slwc_pkg::SIZE_W-1:0] sz,
			input logic typed, input lookup_res_t want);
		lookup_res_t guess;
		in_valid <= 1'b1;
		item_key <= k;
		item_size <= sz;
		do @(posedge clk); while (!in_ready);
		predict_lookup(k, sz, guess);
		pending_results.push_back(typed ? want : guess);
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Stop sending until every outstanding result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [slwc_pkg::DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= slwc_pkg::ADDR_W'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (pready !== 1'b1) begin
			$error("pready: expected 1, actual %0b", pready);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == int'(slwc_pkg::REG_MAX_CAPACITY))
			budget = int'(data[slwc_pkg::CAP_W-1:0]);
	endtask

	task automatic check_budget_reg();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= slwc_pkg::ADDR_W'(int'(slwc_pkg::REG_MAX_CAPACITY) * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== slwc_pkg::DATA_W'(budget)) begin
			$error("max_capacity: expected %0h, actual %0h", budget, prdata);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// New budget between phases: block idle, write, then read back
	task automatic change_budget(input logic [slwc_pkg::DATA_W-1:0] data);
		drain();
		write_reg(int'(slwc_pkg::REG_MAX_CAPACITY), data);
		write_reg(REG_UNUSED, $urandom);
		check_budget_reg();
	endtask

	function automatic logic [slwc_pkg::SIZE_W-1:0] pick_size();
		int lim;
		int sel;
		lim = budget / 6;
		if (lim > 65535)
			lim = 65535;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel <= 2)
			return slwc_pkg::SIZE_W'($urandom);
		if (sel == 3)
			return slwc_pkg::SIZE_W'((budget > 65535) ? 65535 : budget);
		return slwc_pkg::SIZE_W'($urandom_range(0, lim));
	endfunction

	// Result side: random stall bursts, compare each item with the oldest expectation
	always @(posedge clk) begin
		lookup_res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: hit %0b stored %0b evicted %0d used %0h",
						hit, stored, evicted_count, used_total);
					mismatch_count++;
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					if (hit !== want.hit) begin
						$error("hit: expected %0b, actual %0b", want.hit, hit);
						mismatch_count++;
					end
					if (stored !== want.stored) begin
						$error("stored: expected %0b, actual %0b", want.stored, stored);
						mismatch_count++;
					end
					if (evicted_count !== want.evicted) begin
						$error("evicted_count: expected %0d, actual %0d",
							want.evicted, evicted_count);
						mismatch_count++;
					end
					if (used_total !== want.used) begin
						$error("used_total: expected %0h, actual %0h", want.used, used_total);
						mismatch_count++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= (stall_left == 0);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		plan_row_t plan [25 + 4];
		logic [slwc_pkg::KEY_W-1:0] key_pool [KEY_POOL];
		int phase_budget [PHASES];
		logic [slwc_pkg::KEY_W-1:0] k;

		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		item_key = '0;
		item_size = '0;
		out_ready = 1'b0;
		stall_left = 0;
		calm = 1'b0;
		mismatch_count = 0;
		occupied = 0;
		budget = int'(slwc_pkg::CAP_RESET);
		for (int i = 0; i < slwc_pkg::ENTRIES; i++) begin
			cache_live[i] = 1'b0;
			cache_rank[i] = 0;
			cache_key[i] = '0;
			cache_size[i] = '0;
		end

		// Directed table: reset budget, lowered budget, full table, zero budget
		plan = '{
			'{ROW_ITEM,   32'h0, 32'h0000_0000, 16'h0000, 1'b1, '{1'b0, 1'b1, 5'd0, 20'h0}},
			'{ROW_ITEM,   32'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{1'b0, 1'b1, 5'd0, 20'h0FFFF}},
			'{ROW_ITEM,   32'h0, 32'h0000_0000, 16'h04D2, 1'b1, '{1'b1, 1'b1, 5'd0, 20'h0FFFF}},
			'{ROW_ITEM,   32'h0, 32'h0000_0001, 16'h0001, 1'b1, '{1'b0, 1'b1, 5'd0, 20'h10000}},
			'{ROW_ITEM,   32'h0, 32'h0000_0002, 16'hFFFF, 1'b0, '0},
			'{ROW_BUDGET, 32'hFFF0_0064, '0, '0, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0003, 16'd101, 1'b1, '{1'b0, 1'b0, 5'd0, 20'h10000}},
			'{ROW_ITEM,   32'h0, 32'h0000_0003, 16'd100, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0004, 16'h0000, 1'b0, '0},
			'{ROW_BUDGET, 32'h000F_FFFF, '0, '0, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0010, 16'h8000, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0011, 16'h0001, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0012, 16'h7FFF, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0013, 16'h0300, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0004, 16'hFFFF, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0014, 16'h1234, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0015, 16'h0000, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0016, 16'h00FF, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0017, 16'h5555, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0018, 16'hAAAA, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0019, 16'h0010, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_001A, 16'h0020, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_001B, 16'h0040, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_001C, 16'h0080, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_001D, 16'h0002, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_001E, 16'h0004, 1'b0, '0},
			'{ROW_BUDGET, 32'hABC0_0000, '0, '0, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0100, 16'h0000, 1'b0, '0},
			'{ROW_ITEM,   32'h0, 32'h0000_0101, 16'h0001, 1'b1, '{1'b0, 1'b0, 5'd0, 20'h0}}
		};
		phase_budget = '{65536, 1048575, 0, 5000, 300000, 1, 40000, 1048575};

		// Reset once
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_budget_reg();

		// Directed part
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_BUDGET) begin
				change_budget(plan[i].budget_word);
			end else begin
				send_item(plan[i].key, plan[i].size, plan[i].typed, plan[i].want);
				maybe_pause();
			end
		end

		// Random phases: mostly keys from a small pool so hits and LRU order matter
		for (int p = 0; p < PHASES; p++) begin
			change_budget({12'($urandom), slwc_pkg::CAP_W'(phase_budget[p])});
			calm = (p == 3) || (p == PHASES - 1);
			for (int j = 0; j < KEY_POOL; j++)
				key_pool[j] = $urandom;
			for (int n = 0; n < PHASE_LEN; n++) begin
				k = ($urandom_range(0, 6) == 0) ? slwc_pkg::KEY_W'($urandom)
					: key_pool[$urandom_range(0, KEY_POOL - 1)];
				send_item(k, pick_size(), 1'b0, '0);
				maybe_pause();
			end
		end

		// Let the last results arrive, then keep watching for unexpected results
		drain();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
